// ===== rtl/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// Field widths, register indexes, reset values and the status word that the
// line stepper hands to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

   localparam int COLOR_W       = 24;
   localparam int CHAN_W        = 8;
   localparam int ROW_WIDTH_W   = 13;
   localparam int FRAME_BYTES_W = 26;
   localparam int ADDR_W        = 26;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 26;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_BYTES = 1'b1;

   localparam logic [ROW_WIDTH_W-1:0]   ROW_WIDTH_RESET   = 13'd1024;
   localparam logic [FRAME_BYTES_W-1:0] FRAME_BYTES_RESET = 26'd2359296;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   typedef struct packed {
      logic active;
      logic last;
   } lr_status_type;

endpackage

`default_nettype wire

// ===== rtl/lr_channels.sv =====
// ----------------------------------------------------------------------------
// lr_channels: request and response channels of the line rasterizer
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface lr_req_if #(parameter int COORD_BITS = 12);
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [lr_pkg::COLOR_W-1:0]   line_color;

   modport source (output valid, mode, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, mode, start_x, start_y, end_x, end_y, line_color,
                   output ready);
endinterface

interface lr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lr_pkg::ADDR_W-1:0]  byte_address;
   logic [lr_pkg::CHAN_W-1:0]  red;
   logic [lr_pkg::CHAN_W-1:0]  green;
   logic [lr_pkg::CHAN_W-1:0]  blue;
   logic                       write_enable;
   logic                       last_pixel;

   modport source (output valid, byte_address, red, green, blue, write_enable,
                   last_pixel, input ready);
   modport sink   (input valid, byte_address, red, green, blue, write_enable,
                   last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line rasterizer for a 24-bit RGB framebuffer
// Loads lines and emits one framebuffer pixel write per step request on an active line.
// ----------------------------------------------------------------------------
// The block takes one request word per clock cycle while ready. A step on an
// active line yields its pixel word in the response register the next cycle.
// A load word sets up the line and yields nothing; a step while no line is
// active is taken and dropped. The request side is ready whenever the
// response register is empty or being drained in the same cycle, so with a
// ready sink the sustained rate is one pixel per cycle. The cycle is set by
// the address path: a COORD_BITS by 13-bit multiply, an add, a times-three
// add and the compare against the frame size. Configuration writes take
// effect on the next cycle and are meant to happen while the block is idle.
`default_nettype none

module line_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   lr_req_if.sink                         req_ch,
   lr_rsp_if.source                       rsp_ch,
   input  logic                           csr_we,
   input  logic [lr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lr_pkg::*;

   logic [ROW_WIDTH_W-1:0]   row_width;
   logic [FRAME_BYTES_W-1:0] frame_bytes;
   logic signed [COORD_BITS-1:0] cur_x, cur_y;
   logic [COLOR_W-1:0]       pixel_color;
   lr_status_type            status;
   logic [ADDR_W-1:0]        pix_address;
   logic                     pix_we;

   logic req_fire, load, step, emit;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   addr_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic                we_ff, last_ff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign load         = req_fire && (req_ch.mode == MODE_LOAD);
   assign step         = req_fire && (req_ch.mode == MODE_STEP);
   assign emit         = step && status.active;

   lr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .row_width   (row_width),
      .frame_bytes (frame_bytes)
   );

   lr_core #(.COORD_BITS(COORD_BITS)) u_core (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .step        (step),
      .start_x     (req_ch.start_x),
      .start_y     (req_ch.start_y),
      .end_x       (req_ch.end_x),
      .end_y       (req_ch.end_y),
      .line_color  (req_ch.line_color),
      .cur_x       (cur_x),
      .cur_y       (cur_y),
      .pixel_color (pixel_color),
      .status      (status)
   );

   lr_addr #(.COORD_BITS(COORD_BITS)) u_addr (
      .cur_x        (cur_x),
      .cur_y        (cur_y),
      .row_width    (row_width),
      .frame_bytes  (frame_bytes),
      .byte_address (pix_address),
      .write_enable (pix_we)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         addr_ff  <= pix_address;
         color_ff <= pixel_color;
         we_ff    <= pix_we;
         last_ff  <= status.last;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.byte_address = addr_ff;
   assign rsp_ch.red          = color_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_ch.green        = color_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_ch.blue         = color_ff[CHAN_W-1:0];
   assign rsp_ch.write_enable = we_ff;
   assign rsp_ch.last_pixel   = last_ff;

   // A suppressed write never carries an address.
   a_no_addr_when_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !we_ff |-> addr_ff == '0)
      else $error("masked pixel carries a nonzero address");

   // A load always leaves an active line behind it.
   a_load_activates: assert property (@(posedge clock) disable iff (reset)
      load |=> status.active)
      else $error("line not active after load");

   // Emitting the end pixel retires the line.
   a_last_retires: assert property (@(posedge clock) disable iff (reset)
      emit && status.last |=> !status.active)
      else $error("line still active after its end pixel");

   // An emitted pixel shows up in the response register on the next cycle.
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted pixel missing from response register");

   // With an empty response register the request side never stalls.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("request stalled with empty response register");

endmodule

`default_nettype wire

// ===== rtl/lr_csr.sv =====
// ----------------------------------------------------------------------------
// lr_csr: configuration registers
// Holds the framebuffer row width and the framebuffer size in bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [lr_pkg::ROW_WIDTH_W-1:0]   row_width,
   output logic [lr_pkg::FRAME_BYTES_W-1:0] frame_bytes
);
   import lr_pkg::*;

   logic [ROW_WIDTH_W-1:0]   row_width_ff, row_width_in;
   logic [FRAME_BYTES_W-1:0] frame_bytes_ff, frame_bytes_in;

   always_comb begin
      row_width_in   = row_width_ff;
      frame_bytes_in = frame_bytes_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_WIDTH:   row_width_in   = csr_wdata[ROW_WIDTH_W-1:0];
            CSR_FRAME_BYTES: frame_bytes_in = csr_wdata[FRAME_BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= ROW_WIDTH_RESET;
         frame_bytes_ff <= FRAME_BYTES_RESET;
      end else begin
         row_width_ff   <= row_width_in;
         frame_bytes_ff <= frame_bytes_in;
      end
   end

   assign row_width   = row_width_ff;
   assign frame_bytes = frame_bytes_ff;

endmodule

`default_nettype wire

// ===== rtl/lr_core.sv =====
// ----------------------------------------------------------------------------
// lr_core: Bresenham line stepper
// Holds the current point, the end point, the spans, the step directions and
// the error term, and advances one pixel per step until it reaches the end point.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_core #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         step,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic [lr_pkg::COLOR_W-1:0]   line_color,
   output logic signed [COORD_BITS-1:0] cur_x,
   output logic signed [COORD_BITS-1:0] cur_y,
   output logic [lr_pkg::COLOR_W-1:0]   pixel_color,
   output lr_pkg::lr_status_type        status
);
   import lr_pkg::*;

   localparam int C = COORD_BITS;

   logic signed [C-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [C-1:0] target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic signed [C:0]   delta_x_ff, delta_x_in, neg_delta_y_ff, neg_delta_y_in;
   logic                step_x_neg_ff, step_x_neg_in, step_y_neg_ff, step_y_neg_in;
   logic signed [C+2:0] error_ff, error_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                active_ff, active_in;

   logic signed [C:0]   diff_x, diff_y, abs_dx, neg_abs_dy;
   logic signed [C+3:0] e2, dx_wide, ndy_wide, err_wide, err_sum;
   logic                move_x, move_y, at_end;

   // Setup on load.
   assign diff_x     = {end_x[C-1], end_x} - {start_x[C-1], start_x};
   assign diff_y     = {end_y[C-1], end_y} - {start_y[C-1], start_y};
   assign abs_dx     = diff_x[C] ? -diff_x : diff_x;
   assign neg_abs_dy = diff_y[C] ? diff_y : -diff_y;

   // One Bresenham step; both axes may move in the same step.
   assign at_end   = (cur_x_ff == target_x_ff) && (cur_y_ff == target_y_ff);
   assign err_wide = {error_ff[C+2], error_ff};
   assign e2       = {error_ff, 1'b0};
   assign dx_wide  = {{3{delta_x_ff[C]}}, delta_x_ff};
   assign ndy_wide = {{3{neg_delta_y_ff[C]}}, neg_delta_y_ff};
   assign move_x   = (e2 >= ndy_wide);
   assign move_y   = (e2 <= dx_wide);
   assign err_sum  = err_wide + (move_x ? ndy_wide : '0) + (move_y ? dx_wide : '0);

   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      target_x_in    = target_x_ff;
      target_y_in    = target_y_ff;
      delta_x_in     = delta_x_ff;
      neg_delta_y_in = neg_delta_y_ff;
      step_x_neg_in  = step_x_neg_ff;
      step_y_neg_in  = step_y_neg_ff;
      error_in       = error_ff;
      color_in       = color_ff;
      active_in      = active_ff;
      if (load) begin
         cur_x_in       = start_x;
         cur_y_in       = start_y;
         target_x_in    = end_x;
         target_y_in    = end_y;
         delta_x_in     = abs_dx;
         neg_delta_y_in = neg_abs_dy;
         step_x_neg_in  = !(start_x < end_x);
         step_y_neg_in  = !(start_y < end_y);
         error_in       = {{2{abs_dx[C]}}, abs_dx} + {{2{neg_abs_dy[C]}}, neg_abs_dy};
         color_in       = line_color;
         active_in      = 1'b1;
      end else if (step && active_ff) begin
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            error_in = err_sum[C+2:0];
            if (move_x) begin
               cur_x_in = cur_x_ff + (step_x_neg_ff ? {C{1'b1}} : {{(C-1){1'b0}}, 1'b1});
            end
            if (move_y) begin
               cur_y_in = cur_y_ff + (step_y_neg_ff ? {C{1'b1}} : {{(C-1){1'b0}}, 1'b1});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      target_x_ff    <= target_x_in;
      target_y_ff    <= target_y_in;
      delta_x_ff     <= delta_x_in;
      neg_delta_y_ff <= neg_delta_y_in;
      step_x_neg_ff  <= step_x_neg_in;
      step_y_neg_ff  <= step_y_neg_in;
      error_ff       <= error_in;
      color_ff       <= color_in;
   end

   assign cur_x         = cur_x_ff;
   assign cur_y         = cur_y_ff;
   assign pixel_color   = color_ff;
   assign status.active = active_ff;
   assign status.last   = at_end;

endmodule

`default_nettype wire

// ===== rtl/lr_addr.sv =====
// ----------------------------------------------------------------------------
// lr_addr: framebuffer address and bounds check
// Forms (y*row_width + x)*3 without wrap and checks it against the frame size.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_addr #(
   parameter int COORD_BITS = 12
) (
   input  logic signed [COORD_BITS-1:0]     cur_x,
   input  logic signed [COORD_BITS-1:0]     cur_y,
   input  logic [lr_pkg::ROW_WIDTH_W-1:0]   row_width,
   input  logic [lr_pkg::FRAME_BYTES_W-1:0] frame_bytes,
   output logic [lr_pkg::ADDR_W-1:0]        byte_address,
   output logic                             write_enable
);
   import lr_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int PW   = C + ROW_WIDTH_W + 1;
   localparam int AW   = (C + ROW_WIDTH_W + 4 > FRAME_BYTES_W + 1) ?
                         C + ROW_WIDTH_W + 4 : FRAME_BYTES_W + 1;

   logic signed [PW-1:0] prod;
   logic signed [AW-1:0] pix_index, addr3;
   logic [AW-2:0]        limit;
   logic                 in_frame;

   assign prod      = cur_y * $signed({1'b0, row_width});
   assign pix_index = {{(AW-PW){prod[PW-1]}}, prod} + {{(AW-C){cur_x[C-1]}}, cur_x};
   assign addr3     = pix_index + {pix_index[AW-2:0], 1'b0};
   assign limit     = (AW-1)'(frame_bytes);
   assign in_frame  = !addr3[AW-1] && (addr3[AW-2:0] < limit);

   assign write_enable = in_frame;
   assign byte_address = in_frame ? addr3[ADDR_W-1:0] : '0;

endmodule

`default_nettype wire
